// File: hw/rtl/aes_rnd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES round package
// Shared types, round kind codes, the S-box and a GF(2^8) helper.
// ----------------------------------------------------------------------------
package aes_rnd_pkg;

    localparam int unsigned BLOCK_BYTES = 16;
    localparam int unsigned ROWS        = 4;

    // byte 0 is the most significant byte, so {hi, lo} maps straight in
    typedef logic [0:BLOCK_BYTES-1][7:0] block_t;

    typedef enum logic [1:0] {
        ROUND_INIT  = 2'd0,
        ROUND_MID   = 2'd1,
        ROUND_FINAL = 2'd2
    } round_kind_t;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // multiply by x modulo x^8 + x^4 + x^3 + x + 1
    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

// File: hw/rtl/aes_rnd_sub_shift.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES SubBytes and ShiftRows
// Sixteen S-box lookups with the row rotation folded into the byte routing.
// ----------------------------------------------------------------------------
module aes_rnd_sub_shift (
    input  aes_rnd_pkg::block_t state,
    output aes_rnd_pkg::block_t result
);

    genvar c, r;
    generate
        for (c = 0; c < aes_rnd_pkg::ROWS; c++)
        begin : g_col
            for (r = 0; r < aes_rnd_pkg::ROWS; r++)
            begin : g_row
                // row r rotated left by r
                assign result[r + aes_rnd_pkg::ROWS * c] =
                    aes_rnd_pkg::SBOX[state[r + aes_rnd_pkg::ROWS *
                                            ((c + r) % aes_rnd_pkg::ROWS)]];
            end
        end
    endgenerate

endmodule

// File: hw/rtl/aes_rnd_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES MixColumns
// Each column multiplied by the 2,3,1,1 circulant over GF(2^8).
// ----------------------------------------------------------------------------
module aes_rnd_mix (
    input  aes_rnd_pkg::block_t state,
    output aes_rnd_pkg::block_t result
);

    genvar c;
    generate
        for (c = 0; c < aes_rnd_pkg::ROWS; c++)
        begin : g_col
            logic [7:0] a0, a1, a2, a3;
            logic [7:0] d0, d1, d2, d3;

            assign a0 = state[aes_rnd_pkg::ROWS * c];
            assign a1 = state[aes_rnd_pkg::ROWS * c + 1];
            assign a2 = state[aes_rnd_pkg::ROWS * c + 2];
            assign a3 = state[aes_rnd_pkg::ROWS * c + 3];
            assign d0 = aes_rnd_pkg::xtime(a0);
            assign d1 = aes_rnd_pkg::xtime(a1);
            assign d2 = aes_rnd_pkg::xtime(a2);
            assign d3 = aes_rnd_pkg::xtime(a3);

            assign result[aes_rnd_pkg::ROWS * c]     = d0 ^ d1 ^ a1 ^ a2 ^ a3;
            assign result[aes_rnd_pkg::ROWS * c + 1] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
            assign result[aes_rnd_pkg::ROWS * c + 2] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
            assign result[aes_rnd_pkg::ROWS * c + 3] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
        end
    endgenerate

endmodule

// File: hw/rtl/aes128_cipher_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 cipher round
// One encryption round (initial key add, middle or final) per request.
//
// Usage:
//   Request channel: req_valid/req_ready with req_type, state_hi/lo and
//   round_key_hi/lo. Result channel: result_valid/result_ready with
//   result_hi/lo. Each request gives exactly one result, in order.
//   A request taken at a clock edge lands in the input register; the round
//   logic (S-box, row routing, column mix, key add) sits between that and
//   the result register, which takes the round output and offers it once
//   it is empty or being drained.
//   Throughput is one request per cycle while the result register is empty
//   or being drained; both registers then advance together.
//   When the receiver stalls, the result holds, the input register fills,
//   and req_ready drops until result_ready returns. Reset empties both
//   stages; no request is lost or repeated.
//   req_type 3 behaves like an initial round (state XOR key).
// ----------------------------------------------------------------------------
module aes128_cipher_round (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [1:0]  req_type,
    input  logic [63:0] state_hi,
    input  logic [63:0] state_lo,
    input  logic [63:0] round_key_hi,
    input  logic [63:0] round_key_lo,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [63:0] result_hi,
    output logic [63:0] result_lo
);

    logic                s1_valid_reg;
    logic [1:0]          s1_kind_reg;
    aes_rnd_pkg::block_t s1_state_reg;
    aes_rnd_pkg::block_t s1_key_reg;

    logic                out_valid_reg;
    aes_rnd_pkg::block_t out_data_reg;
    aes_rnd_pkg::block_t out_data_next;

    aes_rnd_pkg::block_t sub_shift_out;
    aes_rnd_pkg::block_t mix_out;
    aes_rnd_pkg::block_t pre_key;

    logic out_load;
    logic s1_adv;
    logic req_acc;

    assign out_load  = !out_valid_reg || result_ready;
    assign s1_adv    = s1_valid_reg && out_load;
    assign req_ready = !s1_valid_reg || out_load;
    assign req_acc   = req_valid && req_ready;

    aes_rnd_sub_shift u_sub_shift (
        .state  (s1_state_reg),
        .result (sub_shift_out)
    );

    aes_rnd_mix u_mix (
        .state  (sub_shift_out),
        .result (mix_out)
    );

    always_comb
    begin
        case (s1_kind_reg)
            aes_rnd_pkg::ROUND_MID:   pre_key = mix_out;
            aes_rnd_pkg::ROUND_FINAL: pre_key = sub_shift_out;
            default:                  pre_key = s1_state_reg;
        endcase
        out_data_next = pre_key ^ s1_key_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            s1_kind_reg  <= req_type;
            s1_state_reg <= {state_hi, state_lo};
            s1_key_reg   <= {round_key_hi, round_key_lo};
        end
        if (s1_adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_hi    = out_data_reg[0:7];
    assign result_lo    = out_data_reg[8:15];

    // an accepted request always occupies the input stage next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> s1_valid_reg)
        else $error("accepted request missing from input stage");

    // a stalled input stage keeps its request
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_load) |=>
            (s1_valid_reg && $stable(s1_state_reg) && $stable(s1_key_reg)
             && $stable(s1_kind_reg)))
        else $error("stalled input stage changed");

    // a request moving on shows up as a result with the computed data
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> (out_valid_reg && out_data_reg == $past(out_data_next)))
        else $error("result register did not capture round output");

    // an empty input stage never blocks the request side
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> req_ready)
        else $error("ready low with empty input stage");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 cipher round testbench
// Drives rounds of every kind through aes128_cipher_round. A table of
// directed requests is sent first, then random ones. Random gaps and stalls
// are applied on both channels. Each result is checked against the expectation
// typed into its table entry or, if none, an independent round predictor,
// which builds its own S-box from the GF(2^8) inverse and the affine map.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [1:0]  KIND_SPARE   = 2'd3;   // unused code, acts as key add
    localparam int unsigned RANDOM_REQS  = 1300;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned HOLD_AFTER   = 300;    // results seen before the long hold
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam logic [63:0] ONES         = '1;
    localparam logic [63:0] ALT          = 64'h00ff00ff00ff00ff;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] s_hi;
        logic [63:0] s_lo;
        logic [63:0] k_hi;
        logic [63:0] k_lo;
        logic        typed;
        logic [63:0] e_hi;
        logic [63:0] e_lo;
    } vec_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        req_valid    = 1'b0;
    logic        req_ready;
    logic [1:0]  req_type     = '0;
    logic [63:0] state_hi     = '0;
    logic [63:0] state_lo     = '0;
    logic [63:0] round_key_hi = '0;
    logic [63:0] round_key_lo = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [63:0] result_hi;
    logic [63:0] result_lo;

    // expectation typed into the table, travels with the request payload
    logic        exp_typed = 1'b0;
    logic [63:0] exp_hi    = '0;
    logic [63:0] exp_lo    = '0;

    logic [127:0] pending_blocks [$];
    vec_t         directed_vecs [$];
    int unsigned  mismatches   = 0;
    int unsigned  results_seen = 0;
    int unsigned  cycle_count  = 0;
    logic         rx_holding   = 1'b0;

    aes128_cipher_round dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req_type     (req_type),
        .state_hi     (state_hi),
        .state_lo     (state_lo),
        .round_key_hi (round_key_hi),
        .round_key_lo (round_key_lo),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_hi    (result_hi),
        .result_lo    (result_lo)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Round predictor
    // ------------------------------------------------------------------
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = '0;
        x = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= x;
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    // inverse as v^254, then the affine map
    function automatic logic [7:0] sub_byte(input logic [7:0] v);
        logic [7:0] sq;
        logic [7:0] inv;
        sq  = v;
        inv = 8'h01;
        for (int k = 1; k < 8; k++)
        begin
            sq  = gf_mul(sq, sq);
            inv = gf_mul(inv, sq);
        end
        return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
             ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    endfunction

    function automatic logic [127:0] cipher_round(input logic [1:0] kind,
                                                  input logic [127:0] st,
                                                  input logic [127:0] key);
        aes_rnd_pkg::block_t s;
        aes_rnd_pkg::block_t t;
        aes_rnd_pkg::block_t k;
        logic [7:0]          a0, a1, a2, a3;
        s = st;
        k = key;
        if (kind == aes_rnd_pkg::ROUND_MID || kind == aes_rnd_pkg::ROUND_FINAL)
        begin
            // sub bytes and row rotation in one pass
            for (int c = 0; c < aes_rnd_pkg::ROWS; c++)
                for (int r = 0; r < aes_rnd_pkg::ROWS; r++)
                    t[r + aes_rnd_pkg::ROWS * c] =
                        sub_byte(s[r + aes_rnd_pkg::ROWS * ((c + r) % aes_rnd_pkg::ROWS)]);
            s = t;
            if (kind == aes_rnd_pkg::ROUND_MID)
            begin
                for (int c = 0; c < aes_rnd_pkg::ROWS; c++)
                begin
                    a0 = s[aes_rnd_pkg::ROWS * c];
                    a1 = s[aes_rnd_pkg::ROWS * c + 1];
                    a2 = s[aes_rnd_pkg::ROWS * c + 2];
                    a3 = s[aes_rnd_pkg::ROWS * c + 3];
                    s[aes_rnd_pkg::ROWS * c]     =
                        gf_mul(a0, 8'h02) ^ gf_mul(a1, 8'h03) ^ a2 ^ a3;
                    s[aes_rnd_pkg::ROWS * c + 1] =
                        a0 ^ gf_mul(a1, 8'h02) ^ gf_mul(a2, 8'h03) ^ a3;
                    s[aes_rnd_pkg::ROWS * c + 2] =
                        a0 ^ a1 ^ gf_mul(a2, 8'h02) ^ gf_mul(a3, 8'h03);
                    s[aes_rnd_pkg::ROWS * c + 3] =
                        gf_mul(a0, 8'h03) ^ a1 ^ a2 ^ gf_mul(a3, 8'h02);
                end
            end
        end
        return s ^ k;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2:       return {8{8'($urandom)}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic vec_t rand_vec();
        vec_t        v;
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            v.kind = aes_rnd_pkg::ROUND_MID;
        else if (r < 7)
            v.kind = aes_rnd_pkg::ROUND_FINAL;
        else if (r < 9)
            v.kind = aes_rnd_pkg::ROUND_INIT;
        else
            v.kind = KIND_SPARE;
        v.s_hi  = rand_word();
        v.s_lo  = rand_word();
        v.k_hi  = rand_word();
        v.k_lo  = rand_word();
        v.typed = 1'b0;
        v.e_hi  = '0;
        v.e_lo  = '0;
        return v;
    endfunction

    task automatic add_vec(input logic [1:0] kind, input logic [63:0] s_hi,
                           input logic [63:0] s_lo, input logic [63:0] k_hi,
                           input logic [63:0] k_lo, input logic typed,
                           input logic [63:0] e_hi, input logic [63:0] e_lo);
        directed_vecs.push_back({kind, s_hi, s_lo, k_hi, k_lo, typed, e_hi, e_lo});
    endtask

    // returns at the edge where the request is taken
    task automatic offer_request(input vec_t v);
        req_valid    <= 1'b1;
        req_type     <= v.kind;
        state_hi     <= v.s_hi;
        state_lo     <= v.s_lo;
        round_key_hi <= v.k_hi;
        round_key_lo <= v.k_lo;
        exp_typed    <= v.typed;
        exp_hi       <= v.e_hi;
        exp_lo       <= v.e_lo;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic wait_for_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_blocks.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Scoreboard
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [127:0] want;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                if (exp_typed)
                    pending_blocks.push_back({exp_hi, exp_lo});
                else
                    pending_blocks.push_back(cipher_round(req_type, {state_hi, state_lo},
                                                          {round_key_hi, round_key_lo}));
            end
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (pending_blocks.size() == 0)
                begin
                    $display("%0t ns: result with no request pending: expected none, got %h %h",
                             $time, result_hi, result_lo);
                    mismatches++;
                end
                else
                begin
                    want = pending_blocks.pop_front();
                    if (result_hi !== want[127:64])
                    begin
                        $display("%0t ns: result_hi expected %h, got %h",
                                 $time, want[127:64], result_hi);
                        mismatches++;
                    end
                    if (result_lo !== want[63:0])
                    begin
                        $display("%0t ns: result_lo expected %h, got %h",
                                 $time, want[63:0], result_lo);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stalls, one long hold-off
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned run;
        int unsigned gap;
        bit          held;
        held = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held && results_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                rx_holding   <= 1'b1;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_holding <= 1'b0;
            end
            result_ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                              : $urandom_range(1, 12);
            repeat (run) @(posedge clk);
            gap = idle_gap();
            if (gap != 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    initial
    begin
        vec_t        v;
        int unsigned gap;

        add_vec(aes_rnd_pkg::ROUND_INIT, '0, '0, '0, '0, 1'b1, '0, '0);
        add_vec(aes_rnd_pkg::ROUND_INIT, ONES, ONES, '0, '0, 1'b1, ONES, ONES);
        add_vec(aes_rnd_pkg::ROUND_INIT, '0, '0, ONES, ONES, 1'b1, ONES, ONES);
        add_vec(aes_rnd_pkg::ROUND_INIT, ONES, ONES, ONES, ONES, 1'b1, '0, '0);
        // spare round code is a plain key add
        add_vec(KIND_SPARE, ONES, '0, ALT, ALT, 1'b1, ~ALT, ALT);
        add_vec(KIND_SPARE, 64'h0123456789abcdef, 64'hfedcba9876543210, '0, '0,
                1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210);
        // uniform columns pass the column mix unchanged
        add_vec(aes_rnd_pkg::ROUND_FINAL, '0, '0, '0, '0, 1'b1, {8{8'h63}}, {8{8'h63}});
        add_vec(aes_rnd_pkg::ROUND_MID, '0, '0, '0, '0, 1'b1, {8{8'h63}}, {8{8'h63}});
        add_vec(aes_rnd_pkg::ROUND_FINAL, ONES, ONES, '0, '0, 1'b1, {8{8'h16}}, {8{8'h16}});
        add_vec(aes_rnd_pkg::ROUND_MID, ONES, ONES, '0, '0, 1'b1, {8{8'h16}}, {8{8'h16}});
        add_vec(aes_rnd_pkg::ROUND_MID, '0, '0, ONES, ONES, 1'b1, {8{8'h9c}}, {8{8'h9c}});
        add_vec(aes_rnd_pkg::ROUND_FINAL, '0, '0, ONES, ONES, 1'b1, {8{8'h9c}}, {8{8'h9c}});
        add_vec(aes_rnd_pkg::ROUND_INIT, 64'h3243f6a8885a308d, 64'h313198a2e0370734,
                64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 1'b0, '0, '0);
        add_vec(aes_rnd_pkg::ROUND_MID, 64'h193de3bea0f4e22b, 64'h9ac68d2ae9f84808,
                64'ha0fafe1788542cb1, 64'h23a339392a6c7605, 1'b0, '0, '0);
        add_vec(aes_rnd_pkg::ROUND_FINAL, 64'heb598b1b402ea1c3, 64'hf23813421e84e7d2,
                64'hd014f9a8c9ee2589, 64'he13f0cc8b6630ca6, 1'b0, '0, '0);
        add_vec(aes_rnd_pkg::ROUND_MID, 64'h8000000000000001, 64'h0100000000000080,
                ALT, ~ALT, 1'b0, '0, '0);
        // counting bytes make the row rotation visible
        add_vec(aes_rnd_pkg::ROUND_FINAL, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                '0, '0, 1'b0, '0, '0);
        add_vec(aes_rnd_pkg::ROUND_MID, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                '0, '0, 1'b0, '0, '0);
        add_vec(KIND_SPARE, 64'hdeadbeefcafef00d, 64'h5a5aa5a50ff0f00f,
                64'h7fffffffffffffff, 64'h8000000000000000, 1'b0, '0, '0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_vecs[i])
        begin
            gap = idle_gap();
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            offer_request(directed_vecs[i]);
        end
        wait_for_results();

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            // keep offering while the receiver holds off, and in one burst
            if (rx_holding || (n >= 400 && n < 550))
                gap = 0;
            else
                gap = idle_gap();
            if (n == 800)
                wait_for_results();
            else if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            v = rand_vec();
            offer_request(v);
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
